// File: design/utf8ld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utf8ld_pkg
// Shared types and constants of the lenient UTF-8 decoder.
// ---------------------------------------------------------------------------
package utf8ld_pkg;

  localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // One input request: a raw byte and the end-of-string flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } utf8ld_in_t;

  // One result request.
  typedef struct packed {
    logic [15:0] char_value;
    logic        bad_byte;
    logic [15:0] char_index;
    logic        run_end;
    logic        string_end;
  } utf8ld_out_t;

  // Work for the back end: extra leading bad zeros, then one final result.
  typedef struct packed {
    logic [1:0]  extra;
    logic [15:0] value;
    logic        bad;
    logic        last;
  } utf8ld_desc_t;

endpackage
`default_nettype wire

// File: design/utf8ld_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utf8ld_front
// Classifies each byte, tracks the open sequence and posts result work.
// ---------------------------------------------------------------------------
module utf8ld_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire utf8ld_pkg::utf8ld_in_t  in_data_i,
  output logic                         push_o,
  output utf8ld_pkg::utf8ld_desc_t     desc_o
);
  import utf8ld_pkg::*;

  logic [20:0] code_q, code_d;
  logic [1:0]  need_q, need_d;
  logic [1:0]  held_q, held_d;

  logic [7:0]  b;
  logic        last;
  logic [20:0] ext_code;
  logic [1:0]  need_dec;
  logic [1:0]  held_inc;
  logic [2:0]  pre;
  logic [2:0]  n;
  logic        fresh;

  assign b        = in_data_i.in_byte;
  assign last     = in_data_i.in_last;
  assign ext_code = {code_q[14:0], b[5:0]};
  assign need_dec = need_q - 2'd1;
  assign held_inc = held_q + 2'd1;

  always_comb begin
    code_d       = code_q;
    need_d       = need_q;
    held_d       = held_q;
    n            = 3'd0;
    pre          = 3'd0;
    fresh        = 1'b1;
    desc_o.value = 16'd0;
    desc_o.bad   = 1'b1;
    desc_o.last  = last;

    if (need_q != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        fresh  = 1'b0;
        code_d = ext_code;
        need_d = need_dec;
        held_d = held_inc;
        if (need_dec == 2'd0) begin
          n            = 3'd1;
          desc_o.value = (|ext_code[20:16]) ? REPL_CHAR : ext_code[15:0];
          desc_o.bad   = 1'b0;
        end else if (last) begin
          n = 3'd1 + {1'b0, held_inc};
        end
      end else begin
        // The sequence is broken: flush it, then decode this byte afresh.
        pre = 3'd1 + {1'b0, held_q};
      end
    end

    if (fresh) begin
      code_d = '0;
      need_d = 2'd0;
      held_d = 2'd0;
      n      = pre;
      if (b[7] == 1'b0) begin
        n            = pre + 3'd1;
        desc_o.value = {8'd0, b};
        desc_o.bad   = 1'b0;
      end else if (b[7:5] == 3'b110) begin
        code_d = {16'd0, b[4:0]};
        need_d = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        code_d = {17'd0, b[3:0]};
        need_d = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        code_d = {18'd0, b[2:0]};
        need_d = 2'd3;
      end else begin
        n = pre + 3'd1;
      end
      // A lead byte that ends the string is itself a truncated sequence.
      if (last && (b[7:6] == 2'b11) && (b[7:3] != 5'b11111)) begin
        n = pre + 3'd1;
      end
    end

    if (last) begin
      code_d = '0;
      need_d = 2'd0;
      held_d = 2'd0;
    end

    desc_o.extra = 2'(n - 3'd1);
    push_o       = accept_i && (n != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
      need_q <= '0;
      held_q <= '0;
    end else if (accept_i) begin
      code_q <= code_d;
      need_q <= need_d;
      held_q <= held_d;
    end
  end

endmodule
`default_nettype wire

// File: design/utf8ld_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utf8ld_fifo
// Two-entry queue of result work between the front and the back end.
// ---------------------------------------------------------------------------
module utf8ld_fifo (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire utf8ld_pkg::utf8ld_desc_t  push_data_i,
  input  wire logic                      pop_i,
  output logic                           full_o,
  output logic                           valid_o,
  output utf8ld_pkg::utf8ld_desc_t       pop_data_o
);
  import utf8ld_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  utf8ld_desc_t mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o     = (cnt_q == (PtrW + 1)'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PtrW + 1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/utf8ld_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utf8ld_back
// Expands queued work into results, one a cycle unless stalled, and numbers them.
// ---------------------------------------------------------------------------
module utf8ld_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire utf8ld_pkg::utf8ld_desc_t  desc_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output utf8ld_pkg::utf8ld_out_t        out_data_o
);
  import utf8ld_pkg::*;

  logic        out_valid_q, out_valid_d;
  utf8ld_out_t out_q, out_d;
  logic [1:0]  sub_q, sub_d;
  logic [15:0] count_q, count_d;
  logic        load;
  logic        is_final;

  assign load        = valid_i && (!out_valid_q || !out_stall_i);
  assign is_final    = (sub_q == desc_i.extra);
  assign pop_o       = load && is_final;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_d       = out_q;
    sub_d       = sub_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d      = 1'b1;
      // Every result before the final one of a request is a bad zero.
      out_d.char_value = is_final ? desc_i.value : 16'd0;
      out_d.bad_byte   = is_final ? desc_i.bad : 1'b1;
      out_d.char_index = count_q;
      out_d.run_end    = is_final;
      out_d.string_end = is_final && desc_i.last;
      sub_d            = is_final ? 2'd0 : sub_q + 2'd1;
      count_d          = (is_final && desc_i.last) ? 16'd0 : count_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= '0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
      count_q     <= count_d;
    end
  end

endmodule
`default_nettype wire

// File: design/utf8_lenient_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utf8_lenient_decoder
// Lenient UTF-8 to 16-bit character decoder with running character index.
// ---------------------------------------------------------------------------
// Path: an accepted byte's work enters the work queue; its first result is then
// registered. Throughput: one byte per cycle without output stalls while each
// byte gives at most one result; a byte with k results puts them through the
// single output register in turn. The two-entry queue stalls input only when full.
// Reset: asynchronous, active low; clears sequence state, queue and index.
module utf8_lenient_decoder (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire utf8ld_pkg::utf8ld_in_t  in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output utf8ld_pkg::utf8ld_out_t      out_data_o
);
  import utf8ld_pkg::*;

  logic         accept;
  logic         push;
  logic         pop;
  logic         full;
  logic         q_valid;
  utf8ld_desc_t push_desc;
  utf8ld_desc_t pop_desc;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  utf8ld_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .desc_o    (push_desc)
  );

  utf8ld_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_data_o  (pop_desc)
  );

  utf8ld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .desc_i      (pop_desc),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// File: design/utf8ld_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utf8ld_checker
// Port-level checks on the decoder's result stream.
// ---------------------------------------------------------------------------
module utf8ld_checker (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  input  wire utf8ld_pkg::utf8ld_out_t out_data_o
);
  import utf8ld_pkg::*;

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;

  // A stalled result request holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Consecutive results of one string carry consecutive indexes.
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_data_o.string_end) ##1 out_acc |->
      out_data_o.char_index == $past(out_data_o.char_index) + 16'd1)
    else $error("character index skipped");

  // A new string starts at index zero.
  a_index_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.string_end) ##1 out_acc |-> out_data_o.char_index == 16'd0)
    else $error("index not cleared after string end");

  // The end of a string is also the end of a byte's results.
  a_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.string_end |-> out_data_o.run_end)
    else $error("string end without run end");

  // An error result always carries the value zero.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_byte |-> out_data_o.char_value == 16'd0)
    else $error("bad result with nonzero value");

endmodule

bind utf8_lenient_decoder utf8ld_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the lenient UTF-8 decoder. A short table of byte requests covers
// the extremes, invalid leads, broken and truncated sequences; random strings
// follow. Each result is checked against a table entry or a bench decoder model.
// ---------------------------------------------------------------------------
module testbench;
  import utf8ld_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned RANDOM_BYTES = 250;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned NUM_ROWS     = 29;

  typedef struct {
    utf8ld_in_t  req;
    bit          typed;
    utf8ld_out_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  utf8ld_in_t  in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  utf8ld_out_t out_data_o;

  // Decoder state as the bench sees it.
  logic [20:0] seq_code;
  logic [1:0]  seq_need;
  logic [1:0]  seq_held;
  logic [15:0] char_idx;

  utf8ld_out_t decoded_now[$];
  utf8ld_out_t char_expect_q[$];

  int unsigned err_count;
  int unsigned chars_checked;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned phase_no;

  dir_row_t dir_rows [NUM_ROWS] = '{
    '{'{8'h41, 1'b0}, 1'b1, '{16'h0041, 1'b0, 16'd0, 1'b1, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b1, '{16'h0000, 1'b0, 16'd1, 1'b1, 1'b0}},
    '{'{8'h7F, 1'b0}, 1'b1, '{16'h007F, 1'b0, 16'd2, 1'b1, 1'b0}},
    '{'{8'h80, 1'b0}, 1'b1, '{16'h0000, 1'b1, 16'd3, 1'b1, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b1, '{16'h0000, 1'b1, 16'd4, 1'b1, 1'b0}},
    '{'{8'hF8, 1'b0}, 1'b1, '{16'h0000, 1'b1, 16'd5, 1'b1, 1'b0}},
    '{'{8'hC2, 1'b0}, 1'b0, '0},
    '{'{8'hA9, 1'b0}, 1'b0, '0},
    '{'{8'hEF, 1'b0}, 1'b0, '0},
    '{'{8'hBF, 1'b0}, 1'b0, '0},
    '{'{8'hBF, 1'b0}, 1'b0, '0},
    '{'{8'hF0, 1'b0}, 1'b0, '0},
    '{'{8'h9F, 1'b0}, 1'b0, '0},
    '{'{8'h98, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0}, 1'b0, '0},
    '{'{8'hC0, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0}, 1'b0, '0},
    '{'{8'hE2, 1'b0}, 1'b0, '0},
    '{'{8'h82, 1'b0}, 1'b0, '0},
    '{'{8'h41, 1'b0}, 1'b0, '0},
    '{'{8'hF0, 1'b0}, 1'b0, '0},
    '{'{8'h90, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{8'h7A, 1'b1}, 1'b0, '0},
    '{'{8'hC3, 1'b1}, 1'b1, '{16'h0000, 1'b1, 16'd0, 1'b1, 1'b1}},
    '{'{8'hF0, 1'b0}, 1'b0, '0},
    '{'{8'h90, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b1}, 1'b0, '0}
  };

  utf8_lenient_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_char(logic [15:0] value, logic bad);
    decoded_now.push_back('{value, bad, char_idx, 1'b0, 1'b0});
    char_idx = char_idx + 16'd1;
  endfunction

  // A broken sequence costs one bad zero for its lead and one per held byte.
  function automatic void flush_broken_seq();
    add_char(16'h0000, 1'b1);
    for (int k = 0; k < int'(seq_held); k++) add_char(16'h0000, 1'b1);
    seq_code = '0;
    seq_need = '0;
    seq_held = '0;
  endfunction

  function automatic void decode_byte(utf8ld_in_t req);
    logic [7:0] b;
    logic       fresh;
    b = req.in_byte;
    fresh = 1'b1;
    decoded_now.delete();
    if (seq_need != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        fresh = 1'b0;
        seq_code = {seq_code[14:0], b[5:0]};
        seq_need = seq_need - 2'd1;
        seq_held = seq_held + 2'd1;
        if (seq_need == 2'd0) begin
          add_char((seq_code > 21'h00FFFF) ? REPL_CHAR : seq_code[15:0], 1'b0);
          seq_code = '0;
          seq_held = '0;
        end else if (req.in_last) begin
          flush_broken_seq();
        end
      end else begin
        flush_broken_seq();
      end
    end
    if (fresh) begin
      if (b[7] == 1'b0) begin
        add_char({8'h00, b}, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        seq_code = {16'h0000, b[4:0]};
        seq_need = 2'd1;
        seq_held = 2'd0;
      end else if (b[7:4] == 4'b1110) begin
        seq_code = {17'h00000, b[3:0]};
        seq_need = 2'd2;
        seq_held = 2'd0;
      end else if (b[7:3] == 5'b11110) begin
        seq_code = {18'h00000, b[2:0]};
        seq_need = 2'd3;
        seq_held = 2'd0;
      end else begin
        add_char(16'h0000, 1'b1);
      end
      if (req.in_last && seq_need != 2'd0) flush_broken_seq();
    end
    if (decoded_now.size() > 0) begin
      decoded_now[decoded_now.size() - 1].run_end    = 1'b1;
      decoded_now[decoded_now.size() - 1].string_end = req.in_last;
    end
    if (req.in_last) begin
      seq_code = '0;
      seq_need = '0;
      seq_held = '0;
      char_idx = '0;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(utf8ld_in_t req, bit typed, utf8ld_out_t typed_res);
    decode_byte(req);
    if (typed) begin
      char_expect_q.push_back(typed_res);
    end else begin
      foreach (decoded_now[k]) char_expect_q.push_back(decoded_now[k]);
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= utf8ld_in_t'(9'($urandom));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Mostly well-formed characters, with some truncated ones and raw noise.
  task automatic send_random_string();
    logic [7:0]  text_q[$];
    int unsigned n_chars;
    int unsigned pick;
    int unsigned seq_len;
    int unsigned kept;
    n_chars = $urandom_range(1, 12);
    repeat (n_chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        seq_len = $urandom_range(1, 4);
        kept = (pick < 30) ? $urandom_range(1, seq_len) : seq_len;
        case (seq_len)
          1: text_q.push_back({1'b0, 7'($urandom)});
          2: text_q.push_back({3'b110, 5'($urandom)});
          3: text_q.push_back({4'b1110, 4'($urandom)});
          default: text_q.push_back({5'b11110, 3'($urandom)});
        endcase
        for (int k = 1; k < int'(kept); k++) text_q.push_back({2'b10, 6'($urandom)});
      end
    end
    foreach (text_q[k]) begin
      send_byte('{text_q[k], 1'(k == text_q.size() - 1)}, 1'b0, '0);
    end
  endtask

  task automatic check_char(utf8ld_out_t got);
    utf8ld_out_t want;
    if (char_expect_q.size() == 0) begin
      $error("unexpected result: char_value %h index %0d", got.char_value, got.char_index);
      err_count++;
    end else begin
      want = char_expect_q.pop_front();
      chars_checked++;
      if (got.char_value != want.char_value) begin
        $error("char_value: expected %h, got %h", want.char_value, got.char_value);
        err_count++;
      end
      if (got.bad_byte != want.bad_byte) begin
        $error("bad_byte: expected %b, got %b", want.bad_byte, got.bad_byte);
        err_count++;
      end
      if (got.char_index != want.char_index) begin
        $error("char_index: expected %0d, got %0d", want.char_index, got.char_index);
        err_count++;
      end
      if (got.run_end != want.run_end) begin
        $error("run_end: expected %b, got %b", want.run_end, got.run_end);
        err_count++;
      end
      if (got.string_end != want.string_end) begin
        $error("string_end: expected %b, got %b", want.string_end, got.string_end);
        err_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_char(out_data_o);
  end

  // Ends the run if neither side moves a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Output side. On entering the last phase it holds off long enough for
  // the decoder to fill up and push back on the byte stream.
  initial begin : rx_side
    bit held_off;
    held_off = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase_no == 2 && !held_off) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    seq_code     = '0;
    seq_need     = '0;
    seq_held     = '0;
    char_idx     = '0;
    err_count    = 0;
    chars_checked = 0;
    bytes_sent   = 0;
    quiet_cycles = 0;
    phase_no     = 0;
    tx_idle_pct  = 15;
    rx_idle_pct  = 53;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) send_byte(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].res);

    for (int p = 0; p < 3; p++) begin
      phase_no    = p;
      tx_idle_pct = (p == 0) ? 15 : (p == 1) ? 53 : 0;
      rx_idle_pct = (p == 0) ? 53 : (p == 1) ? 15 : 0;
      while (bytes_sent < NUM_ROWS + (p + 1) * RANDOM_BYTES / 3) send_random_string();
    end
    in_valid_i <= 1'b0;

    while (char_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (char_expect_q.size() != 0) begin
      $error("%0d results never arrived", char_expect_q.size());
      err_count++;
    end

    $display("Decoded %0d bytes into %0d checked characters under three stall patterns,",
             bytes_sent, chars_checked);
    $display("including a long output hold-off that backed up the byte stream.");
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/utf8ld_pkg.sv
design/utf8ld_front.sv
design/utf8ld_fifo.sv
design/utf8ld_back.sv
design/utf8_lenient_decoder.sv
design/utf8ld_checker.sv
tb/testbench.sv
